>>> hdl/tpfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpfd_pkg
// Shared widths, codes, reset values and unit request types for the
// tachometer PID fan duty block.
// ----------------------------------------------------------------------------
package tpfd_pkg;

  // timer width of the tach counter
  localparam int unsigned CounterBits = 8;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned CntW     = 8;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned SpdW     = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned IvlW     = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned DiffW    = 18;
  localparam int unsigned MacW     = 50;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivW     = 32;
  localparam int unsigned DivCntW  = $clog2(DivW + 1);

  localparam logic [WordW-1:0] OffsetStep  = WordW'(64'd1 << CounterBits);
  localparam logic [WordW-1:0] CounterMask = WordW'((64'd1 << CounterBits) - 64'd1);

  // command codes
  localparam logic [CmdW-1:0] CmdOverflow = 2'd0;
  localparam logic [CmdW-1:0] CmdTach     = 2'd1;
  localparam logic [CmdW-1:0] CmdSample   = 2'd2;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgTarget   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainP    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainI    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainD    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgInterval = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgRevScale = 3'd6;

  // register reset values
  localparam logic [SpdW-1:0]  RstTarget   = 16'd1000;
  localparam logic [GainW-1:0] RstGainP    = 16'd2560;
  localparam logic [GainW-1:0] RstGainI    = 16'd512;
  localparam logic [GainW-1:0] RstGainD    = 16'd1331;
  localparam logic [IvlW-1:0]  RstInterval = 8'd10;
  localparam logic [SpdW-1:0]  RstMaxSpeed = 16'd3000;
  localparam logic [WordW-1:0] RstRevScale = 32'd15000000;

  typedef struct packed {
    logic               start;
    logic [DivW-1:0]    dividend;  // left aligned, steps bits used
    logic [DivW-1:0]    divisor;
    logic [DivCntW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic                   start;
    logic                   clr;
    logic signed [MacW-1:0] mcand;
    logic [GainW-1:0]       mplier;
  } mul_req_t;

endpackage
`default_nettype wire

>>> hdl/tpfd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpfd_in_if / tpfd_out_if
// Valid/ready channels for command items and duty results.
// ----------------------------------------------------------------------------
interface tpfd_in_if import tpfd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CmdW-1:0] cmd;
  logic [CntW-1:0] counter_value;

  modport source (output valid, output cmd, output counter_value, input ready);
  modport sink   (input valid, input cmd, input counter_value, output ready);
endinterface

interface tpfd_out_if import tpfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DutyW-1:0] duty;
  logic [SpdW-1:0]  measured_speed;
  logic             overspeed;

  modport source (output valid, output duty, output measured_speed, output overspeed,
                  input ready);
  modport sink   (input valid, input duty, input measured_speed, input overspeed,
                  output ready);
endinterface
`default_nettype wire

>>> hdl/tpfd_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpfd_div
// Radix-2 restoring divider, one quotient bit per cycle, step count per request.
// ----------------------------------------------------------------------------
module tpfd_div import tpfd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire div_req_t        req_i,
  output logic                 busy_o,
  output logic [DivW-1:0]      quo_o
);

  logic [DivW-1:0]    rem_q, rem_d;
  logic [DivW-1:0]    dq_q, dq_d;
  logic [DivW-1:0]    dvs_q, dvs_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW:0]      shifted;
  logic [DivW:0]      trial;

  assign shifted = {rem_q, dq_q[DivW-1]};
  assign trial   = shifted - {1'b0, dvs_q};

  always_comb begin
    rem_d = rem_q;
    dq_d  = dq_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    if (req_i.start) begin
      rem_d = '0;
      dq_d  = req_i.dividend;
      dvs_d = req_i.divisor;
      cnt_d = req_i.steps;
    end else if (cnt_q != '0) begin
      // dividend shifts out the top while quotient bits enter the bottom
      rem_d = trial[DivW] ? shifted[DivW-1:0] : trial[DivW-1:0];
      dq_d  = {dq_q[DivW-2:0], ~trial[DivW]};
      cnt_d = cnt_q - DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quo_o  = dq_q;

endmodule
`default_nettype wire

>>> hdl/tpfd_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpfd_mul
// Shift-add multiply-accumulate, one multiplier bit per cycle, stops once the
// remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module tpfd_mul import tpfd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mul_req_t          req_i,
  output logic                   busy_o,
  output logic signed [MacW-1:0] acc_o
);

  logic signed [MacW-1:0] acc_q, acc_d;
  logic signed [MacW-1:0] mc_q, mc_d;
  logic [GainW-1:0]       mp_q, mp_d;

  always_comb begin
    acc_d = acc_q;
    mc_d  = mc_q;
    mp_d  = mp_q;
    if (req_i.start) begin
      acc_d = req_i.clr ? '0 : acc_q;
      mc_d  = req_i.mcand;
      mp_d  = req_i.mplier;
    end else if (mp_q != '0) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d = mc_q <<< 1;
      mp_d = mp_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mp_q <= '0;
    end else begin
      mp_q <= mp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
  end

  assign busy_o = (mp_q != '0);
  assign acc_o  = acc_q;

endmodule
`default_nettype wire

>>> hdl/tach_pid_fan_duty_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tach_pid_fan_duty_unit
// Tach period capture, speed measurement and PID duty computation.
// ----------------------------------------------------------------------------
// Timer overflow and tach edge transactions update the loop state and give
// no result. A control sample runs through one radix-2 divider and one
// shift-add multiplier in turn: speed divide, error times interval,
// derivative divide, the three gain products (a product ends after the
// gain's highest set bit), then the duty divide. A sample with no measured
// period goes straight to the output stage, one over the speed limit right
// after the speed divide. One sample is worked on at a time; the next
// transaction is taken once the result is in the output register.
module tach_pid_fan_duty_unit import tpfd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  tpfd_in_if.sink                  in_i,
  tpfd_out_if.source               out_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SPD  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_INTS = 4'd3;
  localparam logic [3:0] S_INTW = 4'd4;
  localparam logic [3:0] S_DRVW = 4'd5;
  localparam logic [3:0] S_MPW  = 4'd6;
  localparam logic [3:0] S_MIW  = 4'd7;
  localparam logic [3:0] S_MDW  = 4'd8;
  localparam logic [3:0] S_DUTS = 4'd9;
  localparam logic [3:0] S_DUTW = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  logic [3:0] state_q, state_d;

  // configuration
  logic [SpdW-1:0]  target_q;
  logic [GainW-1:0] kp_q, ki_q, kd_q;
  logic [IvlW-1:0]  ivl_q;
  logic [SpdW-1:0]  fs_q;
  logic [WordW-1:0] rev_q;
  logic [IvlW-1:0]  ivl;
  logic [SpdW-1:0]  fs;

  // loop state
  logic [WordW-1:0]        offset_q, offset_d;
  logic [WordW-1:0]        period_q, period_d;
  logic signed [WordW-1:0] integ_q, integ_d;
  logic signed [ErrW-1:0]  prev_q, prev_d;

  // per-sample working registers
  logic [19:0]             lim11_q, lim11_d;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic [SpdW-1:0]         spd_q, spd_d;
  logic signed [DiffW-1:0] deriv_q, deriv_d;
  logic                    dneg_q, dneg_d;
  logic [SpdW-1:0]         ctl_q, ctl_d;
  logic [DutyW-1:0]        res_duty_q, res_duty_d;
  logic [SpdW-1:0]         res_spd_q, res_spd_d;
  logic                    res_over_q, res_over_d;

  // output register
  logic             out_valid_q;
  logic [DutyW-1:0] out_duty_q;
  logic [SpdW-1:0]  out_spd_q;
  logic             out_over_q;
  logic             out_free;
  logic             out_load;

  // arithmetic units
  div_req_t               div_req;
  logic                   div_busy;
  logic [DivW-1:0]        div_quo;
  mul_req_t               mul_req;
  logic                   mul_busy;
  logic signed [MacW-1:0] mul_acc;

  // combinational helpers
  logic                    in_fire;
  logic [WordW-1:0]        cnt_ext;
  logic                    q_big;
  logic [20:0]             q10;
  logic                    over;
  logic [SpdW-1:0]         spd_sat;
  logic signed [33:0]      isum;
  logic signed [DiffW-1:0] diff;
  logic [DiffW-1:0]        dmag;
  logic signed [DiffW-1:0] dquo;
  logic [41:0]             acc_hi;
  logic [23:0]             prod255;

  tpfd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quo_o  (div_quo)
  );

  tpfd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .busy_o (mul_busy),
    .acc_o  (mul_acc)
  );

  assign ivl = (ivl_q == '0) ? IvlW'(1) : ivl_q;
  assign fs  = (fs_q == '0) ? SpdW'(1) : fs_q;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign cnt_ext    = WordW'(in_i.counter_value) & CounterMask;

  // overspeed when speed > fs + fs/10, i.e. 10*speed > 11*fs
  assign q_big   = (div_quo[31:17] != '0);
  assign q10     = 21'({div_quo[16:0], 3'b000}) + 21'({div_quo[16:0], 1'b0});
  assign over    = q_big || (q10 > {1'b0, lim11_q});
  assign spd_sat = (div_quo[31:16] != '0) ? {SpdW{1'b1}} : div_quo[15:0];

  assign isum = 34'(integ_q) + 34'(mul_acc);
  assign diff = DiffW'(err_q) - DiffW'(prev_q);
  assign dmag = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
  assign dquo = $signed({1'b0, div_quo[ErrW-1:0]});

  assign acc_hi  = mul_acc[MacW-1:8];
  assign prod255 = {ctl_q, 8'd0} - {8'd0, ctl_q};

  always_comb begin
    state_d    = state_q;
    offset_d   = offset_q;
    period_d   = period_q;
    integ_d    = integ_q;
    prev_d     = prev_q;
    lim11_d    = lim11_q;
    err_d      = err_q;
    spd_d      = spd_q;
    deriv_d    = deriv_q;
    dneg_d     = dneg_q;
    ctl_d      = ctl_q;
    res_duty_d = res_duty_q;
    res_spd_d  = res_spd_q;
    res_over_d = res_over_q;
    div_req    = '0;
    mul_req    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_i.cmd)
            CmdOverflow: begin
              offset_d = offset_q + OffsetStep;
            end
            CmdTach: begin
              period_d = cnt_ext + offset_q;
              offset_d = '0;
            end
            CmdSample: begin
              if (period_q == '0) begin
                res_duty_d = {DutyW{1'b1}};
                res_spd_d  = '0;
                res_over_d = 1'b1;
                state_d    = S_OUT;
              end else begin
                lim11_d          = {1'b0, fs, 3'b000} + {3'b000, fs, 1'b0} + {4'd0, fs};
                div_req.start    = 1'b1;
                div_req.dividend = rev_q;
                div_req.divisor  = period_q;
                div_req.steps    = DivCntW'(DivW);
                state_d          = S_SPD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SPD: begin
        if (!div_busy) begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (over) begin
          res_duty_d = {DutyW{1'b1}};
          res_spd_d  = '0;
          res_over_d = 1'b1;
          state_d    = S_OUT;
        end else begin
          spd_d   = spd_sat;
          err_d   = $signed({1'b0, target_q}) - $signed({1'b0, spd_sat});
          state_d = S_INTS;
        end
      end
      S_INTS: begin
        mul_req.start  = 1'b1;
        mul_req.clr    = 1'b1;
        mul_req.mcand  = MacW'(err_q);
        mul_req.mplier = GainW'(ivl);
        state_d        = S_INTW;
      end
      S_INTW: begin
        if (!mul_busy) begin
          // integral saturates to the signed 32-bit range
          if (isum[33:31] != 3'b000 && isum[33:31] != 3'b111) begin
            integ_d = isum[33] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
          end else begin
            integ_d = isum[WordW-1:0];
          end
          prev_d           = err_q;
          dneg_d           = diff[DiffW-1];
          div_req.start    = 1'b1;
          div_req.dividend = {dmag[ErrW-1:0], {(DivW-ErrW){1'b0}}};
          div_req.divisor  = DivW'(ivl);
          div_req.steps    = DivCntW'(ErrW);
          state_d          = S_DRVW;
        end
      end
      S_DRVW: begin
        if (!div_busy) begin
          // truncate toward zero: divide the magnitude, then restore the sign
          deriv_d        = dneg_q ? -dquo : dquo;
          mul_req.start  = 1'b1;
          mul_req.clr    = 1'b1;
          mul_req.mcand  = MacW'(err_q);
          mul_req.mplier = kp_q;
          state_d        = S_MPW;
        end
      end
      S_MPW: begin
        if (!mul_busy) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = MacW'(integ_q);
          mul_req.mplier = ki_q;
          state_d        = S_MIW;
        end
      end
      S_MIW: begin
        if (!mul_busy) begin
          mul_req.start  = 1'b1;
          mul_req.mcand  = MacW'(deriv_q);
          mul_req.mplier = kd_q;
          state_d        = S_MDW;
        end
      end
      S_MDW: begin
        if (!mul_busy) begin
          if (mul_acc[MacW-1]) begin
            ctl_d = '0;
          end else if (acc_hi > 42'(fs)) begin
            ctl_d = fs;
          end else begin
            ctl_d = acc_hi[SpdW-1:0];
          end
          state_d = S_DUTS;
        end
      end
      S_DUTS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {prod255, 8'd0};
        div_req.divisor  = DivW'(fs);
        div_req.steps    = DivCntW'(24);
        state_d          = S_DUTW;
      end
      S_DUTW: begin
        if (!div_busy) begin
          res_duty_d = div_quo[DutyW-1:0];
          res_spd_d  = spd_q;
          res_over_d = 1'b0;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= RstTarget;
      kp_q     <= RstGainP;
      ki_q     <= RstGainI;
      kd_q     <= RstGainD;
      ivl_q    <= RstInterval;
      fs_q     <= RstMaxSpeed;
      rev_q    <= RstRevScale;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTarget:   target_q <= cfg_data_i[SpdW-1:0];
        CfgGainP:    kp_q     <= cfg_data_i[GainW-1:0];
        CfgGainI:    ki_q     <= cfg_data_i[GainW-1:0];
        CfgGainD:    kd_q     <= cfg_data_i[GainW-1:0];
        CfgInterval: ivl_q    <= cfg_data_i[IvlW-1:0];
        CfgMaxSpeed: fs_q     <= cfg_data_i[SpdW-1:0];
        CfgRevScale: rev_q    <= cfg_data_i[WordW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      offset_q <= '0;
      period_q <= '0;
      integ_q  <= '0;
      prev_q   <= '0;
    end else begin
      state_q  <= state_d;
      offset_q <= offset_d;
      period_q <= period_d;
      integ_q  <= integ_d;
      prev_q   <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim11_q    <= lim11_d;
    err_q      <= err_d;
    spd_q      <= spd_d;
    deriv_q    <= deriv_d;
    dneg_q     <= dneg_d;
    ctl_q      <= ctl_d;
    res_duty_q <= res_duty_d;
    res_spd_q  <= res_spd_d;
    res_over_q <= res_over_d;
  end

  // output register
  assign out_free = !out_valid_q || out_o.ready;
  assign out_load = (state_q == S_OUT) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_duty_q <= res_duty_q;
      out_spd_q  <= res_spd_q;
      out_over_q <= res_over_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.duty           = out_duty_q;
  assign out_o.measured_speed = out_spd_q;
  assign out_o.overspeed      = out_over_q;

  // a result is only handed over once both arithmetic units are quiet
  a_out_units_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (!div_busy && !mul_busy))
    else $error("result staged while an arithmetic unit is running");

  // overspeed results always carry full duty and zero speed
  a_over_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.overspeed) |-> (out_o.duty == {DutyW{1'b1}} &&
                                          out_o.measured_speed == '0))
    else $error("overspeed result with wrong payload");

  // an accepted control sample always leaves idle
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.cmd == CmdSample) |=> (state_q != S_IDLE))
    else $error("control sample transaction dropped");

endmodule
`default_nettype wire
